/* hdl/local_extremum_detect_3x3_defines.svh */
// ----------------------------------------------------------------------------
// local_extremum_detect_3x3_defines
// assertion macros shared by the extremum detector rtl
// ----------------------------------------------------------------------------
`ifndef LOCAL_EXTREMUM_DETECT_3X3_DEFINES_SVH
`define LOCAL_EXTREMUM_DETECT_3X3_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LED_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("extremum detector check failed");

// antecedent implies consequent in the next cycle
`define LED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("extremum detector check failed");

`endif

/* hdl/led3x3_pkg.sv */
// ----------------------------------------------------------------------------
// led3x3_pkg
// constants for the 3x3 local extremum detector
// ----------------------------------------------------------------------------
package led3x3_pkg;

  localparam int DEF_MAX_COLS    = 1024;
  localparam int DEF_MAX_ROWS    = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIND_MINIMUM = 2'd2;

  localparam logic [CFG_W-1:0] FRAME_ROWS_RST = 11'd2;
  localparam logic [CFG_W-1:0] FRAME_COLS_RST = 11'd2;

  // candidate centers decided per sample
  localparam int NUM_CAND = 4;

endpackage

/* hdl/local_extremum_detect_3x3.sv */
// ----------------------------------------------------------------------------
// local_extremum_detect_3x3
// streaming strict 3x3 local maximum / minimum detector with line buffers
// ----------------------------------------------------------------------------
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready   sample
// m_axis    out  m_axis_tvalid / m_axis_tready   hit_row, hit_col, hit_value, run_last
// cfg       in   cfg_we_i                        frame_rows, frame_cols, find_minimum
//
// one sample per cycle while each sample releases at most one hit and the output
// is not stalled; a sample that releases several hits holds the output until the
// one-hit-per-cycle output buffer has sent them all. the first hit is offered once
// the releasing sample has passed stage 1 and stage 2. line buffers are one
// dual-column ram read at transfer and written when the sample leaves stage 1.
// reset clears control state and the window registers; line buffer ram needs no clearing pass.
// output stalls back up through the window stage to s_axis_tready.
// ----------------------------------------------------------------------------
`include "local_extremum_detect_3x3_defines.svh"

module local_extremum_detect_3x3 #(
  parameter int MAX_COLS    = led3x3_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS    = led3x3_pkg::DEF_MAX_ROWS,
  parameter int SAMPLE_BITS = led3x3_pkg::DEF_SAMPLE_BITS,
  localparam int ROW_W   = $clog2(MAX_ROWS),
  localparam int COL_W   = $clog2(MAX_COLS),
  localparam int IN_TW   = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_TW  = ((ROW_W + COL_W + SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [led3x3_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [led3x3_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [IN_TW-1:0]                    s_axis_tdata,   // sample
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [OUT_TW-1:0]                   m_axis_tdata,   // hit_row, hit_col, hit_value
  output logic                                m_axis_tlast    // run_last
);

  localparam int REW = $clog2(MAX_ROWS + 1);
  localparam int CEW = $clog2(MAX_COLS + 1);
  localparam int SW  = SAMPLE_BITS;
  localparam int NC  = led3x3_pkg::NUM_CAND;
  localparam int CEN_R [NC] = '{1, 1, 2, 2};
  localparam int CEN_C [NC] = '{1, 2, 1, 2};

  // configuration
  logic [led3x3_pkg::CFG_W-1:0] rows_cfg_q, cols_cfg_q;
  logic                         find_min_q;
  logic [REW-1:0]               rows_eff;
  logic [CEW-1:0]               cols_eff;

  // position counters
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic             last_row, last_col;

  // stage 1: accepted sample and line buffer read
  logic                   s1_valid_q;
  logic signed [SW-1:0]   s1_sample_q;
  logic [ROW_W-1:0]       s1_row_q;
  logic [COL_W-1:0]       s1_col_q;
  logic                   s1_lr_q, s1_lc_q;
  logic [2*SW-1:0]        lb_mem [MAX_COLS];
  logic [2*SW-1:0]        rd_q;
  logic                   fwd_q;
  logic [2*SW-1:0]        fwd_data_q;
  logic signed [SW-1:0]   s1_above, s1_two;

  // stage 2: window
  logic                   s2_valid_q;
  logic [ROW_W-1:0]       s2_row_q;
  logic [COL_W-1:0]       s2_col_q;
  logic                   s2_lr_q, s2_lc_q;
  logic signed [SW-1:0]   win_q [3][3];
  logic [2:0]             row_ok, col_ok;
  logic [NC-1:0]          is_ext, cand_en, hits;

  // output buffer
  logic [NC-1:0]          pend_q;
  logic [ROW_W-1:0]       ent_row_q [NC];
  logic [COL_W-1:0]       ent_col_q [NC];
  logic signed [SW-1:0]   ent_val_q [NC];
  logic [NC-1:0]          sel_oh;
  logic [1:0]             sel_idx;

  logic in_acc, out_acc, out_free, s2_adv, s2_ready, s1_adv, s1_ready;

  // effective frame size
  always_comb begin
    if (rows_cfg_q == '0) begin
      rows_eff = REW'(1);
    end else if (32'(rows_cfg_q) > 32'(MAX_ROWS)) begin
      rows_eff = REW'(MAX_ROWS);
    end else begin
      rows_eff = REW'(rows_cfg_q);
    end
    if (cols_cfg_q == '0) begin
      cols_eff = CEW'(1);
    end else if (32'(cols_cfg_q) > 32'(MAX_COLS)) begin
      cols_eff = CEW'(MAX_COLS);
    end else begin
      cols_eff = CEW'(cols_cfg_q);
    end
  end

  assign last_row = (REW'(row_q) == rows_eff - REW'(1));
  assign last_col = (CEW'(col_q) == cols_eff - CEW'(1));

  // handshake chain
  assign out_acc  = m_axis_tvalid && m_axis_tready;
  assign out_free = (pend_q == '0) || (out_acc && m_axis_tlast);
  assign s2_adv   = s2_valid_q && out_free;
  assign s2_ready = !s2_valid_q || out_free;
  assign s1_adv   = s1_valid_q && s2_ready;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign s_axis_tready = s1_ready;
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  // config registers and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= led3x3_pkg::FRAME_ROWS_RST;
      cols_cfg_q <= led3x3_pkg::FRAME_COLS_RST;
      find_min_q <= 1'b0;
      row_q      <= '0;
      col_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        led3x3_pkg::REG_FRAME_ROWS: begin
          rows_cfg_q <= cfg_data_i;
          row_q      <= '0;
          col_q      <= '0;
        end
        led3x3_pkg::REG_FRAME_COLS: begin
          cols_cfg_q <= cfg_data_i;
          row_q      <= '0;
          col_q      <= '0;
        end
        led3x3_pkg::REG_FIND_MINIMUM: begin
          find_min_q <= cfg_data_i[0];
          row_q      <= '0;
          col_q      <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_acc) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // line buffer ram: {two rows above, row above}
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      lb_mem[s1_col_q] <= {s1_above, s1_sample_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= lb_mem[col_q];
    end
  end

  // same column read and written in one cycle (single column frames)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_acc) begin
      fwd_q <= s1_adv && (col_q == s1_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_data_q <= {s1_above, s1_sample_q};
    end
  end

  assign s1_above = fwd_q ? fwd_data_q[SW-1:0]    : rd_q[SW-1:0];
  assign s1_two   = fwd_q ? fwd_data_q[2*SW-1:SW] : rd_q[2*SW-1:SW];

  // stage 1 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q <= $signed(s_axis_tdata[SW-1:0]);
      s1_row_q    <= row_q;
      s1_col_q    <= col_q;
      s1_lr_q     <= last_row;
      s1_lc_q     <= last_col;
    end
  end

  // stage 2: window shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[k][j] <= '0;
        end
      end
    end else begin
      if (s2_ready) begin
        s2_valid_q <= s1_adv;
      end
      if (s1_adv) begin
        for (int k = 0; k < 3; k++) begin
          win_q[k][0] <= win_q[k][1];
          win_q[k][1] <= win_q[k][2];
        end
        win_q[0][2] <= s1_two;
        win_q[1][2] <= s1_above;
        win_q[2][2] <= s1_sample_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_row_q <= s1_row_q;
      s2_col_q <= s1_col_q;
      s2_lr_q  <= s1_lr_q;
      s2_lc_q  <= s1_lc_q;
    end
  end

  // neighbor presence inside the frame
  assign row_ok = {1'b1, s2_row_q != '0, s2_row_q > ROW_W'(1)};
  assign col_ok = {1'b1, s2_col_q != '0, s2_col_q > COL_W'(1)};

  always_comb begin
    int kr, kc;
    logic signed [SW-1:0] ctr, nb;
    kr  = 0;
    kc  = 0;
    ctr = '0;
    nb  = '0;
    for (int e = 0; e < NC; e++) begin
      ctr       = win_q[CEN_R[e]][CEN_C[e]];
      is_ext[e] = 1'b1;
      for (int dr = 0; dr < 3; dr++) begin
        for (int dc = 0; dc < 3; dc++) begin
          kr = CEN_R[e] + dr - 1;
          kc = CEN_C[e] + dc - 1;
          if (!(dr == 1 && dc == 1) && kr <= 2 && kc <= 2) begin
            if (row_ok[kr] && col_ok[kc]) begin
              nb = win_q[kr][kc];
              if (find_min_q ? !(ctr < nb) : !(ctr > nb)) begin
                is_ext[e] = 1'b0;
              end
            end
          end
        end
      end
    end
  end

  assign cand_en = {s2_lr_q & s2_lc_q, s2_lr_q & col_ok[1],
                    row_ok[1] & s2_lc_q, row_ok[1] & col_ok[1]};
  assign hits    = cand_en & is_ext;

  // output buffer, one hit per transfer in raster order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (s2_adv) begin
      pend_q <= hits;
    end else if (out_acc) begin
      pend_q <= pend_q & ~sel_oh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      ent_row_q[0] <= s2_row_q - 1'b1;
      ent_col_q[0] <= s2_col_q - 1'b1;
      ent_val_q[0] <= win_q[1][1];
      ent_row_q[1] <= s2_row_q - 1'b1;
      ent_col_q[1] <= s2_col_q;
      ent_val_q[1] <= win_q[1][2];
      ent_row_q[2] <= s2_row_q;
      ent_col_q[2] <= s2_col_q - 1'b1;
      ent_val_q[2] <= win_q[2][1];
      ent_row_q[3] <= s2_row_q;
      ent_col_q[3] <= s2_col_q;
      ent_val_q[3] <= win_q[2][2];
    end
  end

  always_comb begin
    sel_idx = '0;
    for (int i = NC - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel_idx = 2'(i);
      end
    end
    sel_oh = NC'(1) << sel_idx;
  end

  assign m_axis_tvalid = (pend_q != '0);
  assign m_axis_tlast  = ((pend_q & ~sel_oh) == '0);
  assign m_axis_tdata  = OUT_TW'({ent_val_q[sel_idx], ent_col_q[sel_idx],
                                  ent_row_q[sel_idx]});

  `LED_ASSERT_NEXT(a_fwd_on_same_col, in_acc && s1_adv && (col_q == s1_col_q), fwd_q)
  `LED_ASSERT_SAME(a_load_only_when_drained, s2_adv,
                   (pend_q == '0) || $onehot(pend_q))
  `LED_ASSERT_SAME(a_accept_frees_stage1, in_acc, !s1_valid_q || s1_adv)
  `LED_ASSERT_NEXT(a_col_in_frame, 1'b1, CEW'(col_q) < cols_eff)

endmodule
